/* sv/lvms_pkg.sv */
// Package with shared types, codes and reset constants of the maze step unit.
`timescale 1ns / 1ps

package lvms_pkg;

    // Default sizes of the grid and of one visit counter.
    localparam int GRID_SIDE_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths of the streams and the configuration port.
    localparam int POS_OUT_W   = 4;
    localparam int VISITS_W    = 16;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    // Reset values of the start registers.
    localparam logic [3:0] START_COL_RST     = 4'd12;
    localparam logic [3:0] START_ROW_RST     = 4'd0;
    localparam logic [1:0] START_HEADING_RST = 2'd2;

    // Headings, which also number the four neighbours.
    typedef enum logic [1:0] {
        HEAD_UP    = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_DOWN  = 2'd2,
        HEAD_LEFT  = 2'd3
    } heading_t;

    // Commands carried in tuser.
    typedef enum logic {
        CMD_STEP    = 1'b0,
        CMD_RESTART = 1'b1
    } command_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_COL     = 2'd0,
        CFG_START_ROW     = 2'd1,
        CFG_START_HEADING = 2'd2
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_FETCH,
        ST_FINISH
    } seq_state_t;

    // Start values handed from the configuration registers to the sequencer.
    typedef struct packed {
        logic [3:0] col;
        logic [3:0] row;
        logic [1:0] heading;
    } start_cfg_t;

    // One result item, packed from the lowest bit up as new_heading first.
    typedef struct packed {
        logic                 stuck;
        logic [VISITS_W-1:0]  cell_visits;
        logic [POS_OUT_W-1:0] cell_row;
        logic [POS_OUT_W-1:0] cell_col;
        logic                 turned_left;
        logic [1:0]           turn_steps;
        logic [1:0]           new_heading;
    } result_t;

endpackage

/* sv/lvms_store.sv */
// Visit count memory with one write port and one registered read port.
`timescale 1ns / 1ps

module lvms_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lvms_seq.sv */
// Step sequencer: walks the neighbours through one shared compare unit and updates the store.
`timescale 1ns / 1ps

module lvms_seq #(
    parameter int GRID_SIDE  = lvms_pkg::GRID_SIDE_DEF,
    parameter int COUNT_BITS = lvms_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_command,
    input  logic                 in_wall_ahead,
    input  logic                 in_wall_on_right,
    input  logic                 in_wall_on_left,
    input  lvms_pkg::start_cfg_t start_cfg,
    input  logic                 out_free,
    output logic                 res_load,
    output lvms_pkg::result_t    res
);

    import lvms_pkg::*;

    localparam int POS_W  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [POS_W-1:0]      POS_MAX   = POS_W'(GRID_SIDE - 1);
    localparam logic [ADDR_W-1:0]     ADDR_LAST = ADDR_W'(CELLS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {{(COUNT_BITS-1){1'b1}}, 1'b0};

    localparam logic [POS_W-1:0] RESET_COL =
        (int'(START_COL_RST) >= GRID_SIDE) ? POS_MAX : POS_W'(START_COL_RST);
    localparam logic [POS_W-1:0] RESET_ROW =
        (int'(START_ROW_RST) >= GRID_SIDE) ? POS_MAX : POS_W'(START_ROW_RST);

    seq_state_t            state_reg, state_next;
    logic [1:0]            k_reg, k_next;
    logic                  found_reg, found_next;
    logic [1:0]            best_reg, best_next;
    logic [COUNT_BITS-1:0] best_val_reg, best_val_next;
    logic [3:0]            blk_reg, blk_next;
    logic [POS_W-1:0]      col_reg, col_next;
    logic [POS_W-1:0]      row_reg, row_next;
    logic [1:0]            heading_reg, heading_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  emit_reg, emit_next;
    result_t               res_reg, res_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    logic [1:0]            sel_dir;
    logic [POS_W-1:0]      nbr_col;
    logic [POS_W-1:0]      nbr_row;
    logic [3:0]            edge_blk;
    logic [3:0]            wall_blk;
    logic                  cand_wins;
    logic [COUNT_BITS-1:0] best_inc;

    // Cell address is column times side plus row.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [POS_W-1:0] c,
        input logic [POS_W-1:0] r
    );
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(ADDR_W'(c) * ADDR_W'(GRID_SIDE));
        return prod + ADDR_W'(r);
    endfunction

    // Clamp a 4-bit start coordinate into the grid.
    function automatic logic [POS_W-1:0] clamp_start(input logic [3:0] v);
        logic [POS_W-1:0] res_pos;
        res_pos = (int'(v) >= GRID_SIDE) ? POS_MAX : POS_W'(v);
        return res_pos;
    endfunction

    lvms_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS),
        .DEPTH  (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Neighbour position in one direction: the scan index or the chosen best.
    assign sel_dir = (state_reg == ST_DECIDE) ? best_reg : k_reg;

    always_comb
    begin
        nbr_col = col_reg;
        nbr_row = row_reg;
        unique case (heading_t'(sel_dir))
            HEAD_UP:    nbr_row = row_reg - 1'b1;
            HEAD_RIGHT: nbr_col = col_reg + 1'b1;
            HEAD_DOWN:  nbr_row = row_reg + 1'b1;
            HEAD_LEFT:  nbr_col = col_reg - 1'b1;
        endcase
    end

    // Neighbours off the grid and behind sensed walls.
    assign edge_blk = {col_reg == '0, row_reg == POS_MAX, col_reg == POS_MAX, row_reg == '0};

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            wall_blk[j] = ((2'(j) == heading_reg) && in_wall_ahead)
                        || ((2'(j) == heading_reg + 2'd1) && in_wall_on_right)
                        || ((2'(j) == heading_reg + 2'd3) && in_wall_on_left);
        end
    end

    // Shared compare and saturating increment.
    assign cand_wins = !found_reg || (mem_rdata < best_val_reg);
    assign best_inc  = (best_val_reg < COUNT_MAX) ? best_val_reg + 1'b1 : best_val_reg;

    // Next state and outputs.
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        blk_next      = blk_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        heading_next  = heading_reg;
        clr_addr_next = clr_addr_reg;
        emit_next     = emit_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_raddr     = cell_addr(nbr_col, nbr_row);
        in_ready      = 1'b0;
        res_load      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_LAST)
                begin
                    clr_addr_next = '0;
                    state_next    = emit_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command_t'(in_command) == CMD_RESTART)
                    begin
                        col_next     = clamp_start(start_cfg.col);
                        row_next     = clamp_start(start_cfg.row);
                        heading_next = start_cfg.heading;
                        emit_next    = 1'b1;
                        res_next.new_heading = start_cfg.heading;
                        res_next.turn_steps  = '0;
                        res_next.turned_left = 1'b0;
                        res_next.cell_col    = POS_OUT_W'(clamp_start(start_cfg.col));
                        res_next.cell_row    = POS_OUT_W'(clamp_start(start_cfg.row));
                        res_next.cell_visits = '0;
                        res_next.stuck       = 1'b0;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        blk_next   = edge_blk | wall_blk;
                        k_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_READ;
                    end
                end
            end

            // Issue the read of an open neighbour, or skip a blocked one.
            ST_READ:
            begin
                if (blk_reg[k_reg])
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? ST_DECIDE : ST_READ;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end

            // Keep the least-visited neighbour; earlier directions win ties.
            ST_CMP:
            begin
                if (cand_wins)
                begin
                    found_next    = 1'b1;
                    best_next     = k_reg;
                    best_val_next = mem_rdata;
                end
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == 2'd3) ? ST_DECIDE : ST_READ;
            end

            ST_DECIDE:
            begin
                mem_raddr = cell_addr(col_reg, row_reg);
                if (!found_reg)
                begin
                    res_next.new_heading = heading_reg;
                    res_next.turn_steps  = '0;
                    res_next.turned_left = 1'b0;
                    res_next.cell_col    = POS_OUT_W'(col_reg);
                    res_next.cell_row    = POS_OUT_W'(row_reg);
                    res_next.stuck       = 1'b1;
                    state_next           = ST_FETCH;
                end
                else
                begin
                    // Turn toward the target, move and count the visit.
                    mem_we       = 1'b1;
                    mem_waddr    = cell_addr(nbr_col, nbr_row);
                    mem_wdata    = best_inc;
                    col_next     = nbr_col;
                    row_next     = nbr_row;
                    heading_next = best_reg;
                    res_next.new_heading = best_reg;
                    res_next.turned_left = heading_reg > best_reg;
                    res_next.turn_steps  = (heading_reg > best_reg) ? heading_reg - best_reg
                                                                     : best_reg - heading_reg;
                    res_next.cell_col    = POS_OUT_W'(nbr_col);
                    res_next.cell_row    = POS_OUT_W'(nbr_row);
                    res_next.cell_visits = VISITS_W'(best_inc);
                    res_next.stuck       = 1'b0;
                    state_next           = ST_FINISH;
                end
            end

            // The current cell's count arrives for a stuck result.
            ST_FETCH:
            begin
                res_next.cell_visits = VISITS_W'(mem_rdata);
                state_next           = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    emit_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            k_reg        <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            blk_reg      <= '0;
            col_reg      <= RESET_COL;
            row_reg      <= RESET_ROW;
            heading_reg  <= START_HEADING_RST;
            clr_addr_reg <= '0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            blk_reg      <= blk_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            heading_reg  <= heading_next;
            clr_addr_reg <= clr_addr_next;
            emit_reg     <= emit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule

/* sv/least_visited_maze_step_unit.sv */
// Top level of the least-visited maze step unit.
`timescale 1ns / 1ps
//
// A maze robot explorer. The slave stream takes one command per transaction:
// tuser[0] = 0 is one exploration step using the wall bits in tdata, and
// tuser[0] = 1 restarts: the visit counts are cleared and position and
// heading load from the start registers. Each command gives one result on
// the master stream with the new heading, turn, position, visit count and a
// stuck flag. Start registers are written over the cfg channel (index 0
// column, 1 row, 2 heading), which is always ready.
// A step accepts the command, reads the visits of the open neighbours one at a
// time through the memory read port and one comparator, skipping the blocked
// ones, then decides and hands off. A stuck step also fetches the current count.
// A restart sweeps the memory, one entry per cycle. After reset the same sweep
// runs with s_tready low and gives no result. The block takes one command at a
// time. A finished result waits in the output register while m_tready is low;
// the next command can be accepted meanwhile, and its result then waits for it.

module least_visited_maze_step_unit #(
    parameter int GRID_SIDE  = lvms_pkg::GRID_SIDE_DEF,
    parameter int COUNT_BITS = lvms_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Bits from 0: wall_ahead, wall_on_right, wall_on_left, zero fill.
    input  logic [lvms_pkg::S_TDATA_W-1:0]     s_tdata,
    // Bit 0: command.
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Bits from 0: new_heading[1:0], turn_steps[3:2], turned_left[4], cell_col[8:5],
    // cell_row[12:9], cell_visits[28:13], stuck[29], zero fill.
    output logic [lvms_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lvms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lvms_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import lvms_pkg::*;

    start_cfg_t               cfg_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     out_free;
    logic                     res_load;
    result_t                  res;

    // Configuration write transactions.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col     <= START_COL_RST;
            cfg_reg.row     <= START_ROW_RST;
            cfg_reg.heading <= START_HEADING_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_COL:     cfg_reg.col     <= cfg_data;
                CFG_START_ROW:     cfg_reg.row     <= cfg_data;
                CFG_START_HEADING: cfg_reg.heading <= cfg_data[1:0];
                default:           cfg_reg         <= cfg_reg;
            endcase
        end
    end

    lvms_seq #(
        .GRID_SIDE  (GRID_SIDE),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_command       (s_tuser[0]),
        .in_wall_ahead    (s_tdata[0]),
        .in_wall_on_right (s_tdata[1]),
        .in_wall_on_left  (s_tdata[2]),
        .start_cfg        (cfg_reg),
        .out_free         (out_free),
        .res_load         (res_load),
        .res              (res)
    );

    // Output register.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_tdata_reg <= M_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/lvms_checker.sv */
// Port-level checker for the maze step unit and its bind.
`timescale 1ns / 1ps

module lvms_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [0:0]                         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lvms_pkg::M_TDATA_W-1:0]     m_tdata
);

    // A result held back by the receiver stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A command keeps the unit busy, so commands are never accepted back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted in back-to-back cycles");

    // A restart sweeps the store, so the unit stays busy for a while.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready ##1 !s_tready)
        else $error("restart finished without clearing the store");

    // A stuck result reports no turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29] |-> m_tdata[3:2] == 2'd0 && !m_tdata[4])
        else $error("stuck result reports a turn");

    // A left turn always has at least one quarter turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3:2] != 2'd0)
        else $error("left turn without quarter turns");

endmodule

bind least_visited_maze_step_unit lvms_checker u_lvms_checker (.*);

/* test/least_visited_maze_step_unit_tb.sv */
// Self-checking testbench for the least-visited maze step unit.
`timescale 1ns / 1ps

module least_visited_maze_step_unit_tb;

    import lvms_pkg::*;

    localparam int GRID        = GRID_SIDE_DEF;
    localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 2;
    localparam int RES_W       = $bits(result_t);
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int IDLE_PCT    = 27;
    localparam int CYCLE_LIMIT = 1_000_000;

    // One row of the directed table; exp is used only where typed is set.
    typedef struct packed {
        command_t   cmd;
        logic [2:0] walls;      // {left, right, ahead}
        logic       typed;
        result_t    exp;
    } stim_row_t;

    // Stuck result with the reset start values: facing down on the top edge, all walls.
    localparam result_t STUCK_AT_START = '{
        stuck: 1'b1, cell_visits: '0, cell_row: START_ROW_RST, cell_col: START_COL_RST,
        turned_left: 1'b0, turn_steps: 2'd0, new_heading: START_HEADING_RST};

    // Restart result with the reset start values.
    localparam result_t RESTART_AT_START = '{
        stuck: 1'b0, cell_visits: '0, cell_row: START_ROW_RST, cell_col: START_COL_RST,
        turned_left: 1'b0, turn_steps: 2'd0, new_heading: START_HEADING_RST};

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{CMD_STEP,    3'b111, 1'b1, STUCK_AT_START},
        '{CMD_STEP,    3'b000, 1'b0, '0},
        '{CMD_STEP,    3'b001, 1'b0, '0},
        '{CMD_STEP,    3'b010, 1'b0, '0},
        '{CMD_STEP,    3'b011, 1'b0, '0},
        '{CMD_STEP,    3'b100, 1'b0, '0},
        '{CMD_STEP,    3'b101, 1'b0, '0},
        '{CMD_STEP,    3'b110, 1'b0, '0},
        '{CMD_STEP,    3'b111, 1'b0, '0},
        '{CMD_STEP,    3'b111, 1'b0, '0},
        '{CMD_RESTART, 3'b000, 1'b1, RESTART_AT_START},
        '{CMD_STEP,    3'b111, 1'b1, STUCK_AT_START},
        '{CMD_STEP,    3'b000, 1'b0, '0},
        '{CMD_STEP,    3'b000, 1'b0, '0},
        '{CMD_STEP,    3'b000, 1'b0, '0},
        '{CMD_STEP,    3'b001, 1'b0, '0},
        '{CMD_STEP,    3'b110, 1'b0, '0},
        '{CMD_STEP,    3'b000, 1'b0, '0},
        '{CMD_STEP,    3'b100, 1'b0, '0},
        '{CMD_STEP,    3'b010, 1'b0, '0},
        '{CMD_RESTART, 3'b111, 1'b1, RESTART_AT_START}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // Bits from 0: wall_ahead, wall_on_right, wall_on_left, zero fill.
    logic [S_TDATA_W-1:0]   s_tdata;
    // Bit 0: command.
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // Bits from 0: new_heading, turn_steps, turned_left, cell_col, cell_row,
    // cell_visits, stuck, zero fill.
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted robot state and start registers.
    int visit_count [GRID*GRID];
    int robot_col;
    int robot_row;
    int robot_dir;
    int start_col_q;
    int start_row_q;
    int start_dir_q;

    result_t expected_results [$];

    bit quiet;
    int failures;
    int cycles;
    int steps_sent;
    int restarts_sent;
    int stuck_predicted;
    int cfg_writes;
    int results_checked;

    least_visited_maze_step_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Next step of the explorer: updates the predicted state and returns its result.
    function automatic result_t predict_move(input command_t cmd, input logic [2:0] walls);
        result_t res;
        bit [3:0] blocked;
        int nb_col [4];
        int nb_row [4];
        int face;
        int best;
        int best_count;
        int here;
        bit found;
        res = '0;
        if (cmd == CMD_RESTART)
        begin
            foreach (visit_count[k])
                visit_count[k] = 0;
            robot_col = start_col_q;
            robot_row = start_row_q;
            robot_dir = start_dir_q;
        end
        else
        begin
            face   = robot_dir;
            nb_col = '{robot_col, robot_col + 1, robot_col, robot_col - 1};
            nb_row = '{robot_row - 1, robot_row, robot_row + 1, robot_row};
            // Grid edges first; the cell behind has no sensor.
            blocked = {robot_col == 0, robot_row == GRID - 1,
                       robot_col == GRID - 1, robot_row == 0};
            if (walls[0])
                blocked[face] = 1'b1;
            if (walls[1])
                blocked[(face + 1) % 4] = 1'b1;
            if (walls[2])
                blocked[(face + 3) % 4] = 1'b1;
            found      = 1'b0;
            best       = 0;
            best_count = 0;
            // Least-visited open neighbour, the lower heading wins a tie.
            for (int d = 0; d < 4; d++)
            begin
                if (!blocked[d])
                begin
                    here = nb_col[d] * GRID + nb_row[d];
                    if (!found || visit_count[here] < best_count)
                    begin
                        found      = 1'b1;
                        best       = d;
                        best_count = visit_count[here];
                    end
                end
            end
            if (!found)
                res.stuck = 1'b1;
            else
            begin
                res.turned_left = face > best;
                res.turn_steps  = 2'(face > best ? face - best : best - face);
                robot_dir = best;
                robot_col = nb_col[best];
                robot_row = nb_row[best];
                here = robot_col * GRID + robot_row;
                if (visit_count[here] < COUNT_MAX)
                    visit_count[here]++;
            end
        end
        res.new_heading = 2'(robot_dir);
        res.cell_col    = 4'(robot_col);
        res.cell_row    = 4'(robot_row);
        res.cell_visits = 16'(visit_count[robot_col * GRID + robot_row]);
        return res;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf("heading=%0d turns=%0d left=%0d col=%0d row=%0d visits=%0d stuck=%0d",
                         r.new_heading, r.turn_steps, r.turned_left, r.cell_col,
                         r.cell_row, r.cell_visits, r.stuck);
    endfunction

    task automatic log_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Sends one command; the expectation is queued once the transaction is taken.
    task automatic issue_command(input command_t cmd, input logic [2:0] walls,
                                 input bit typed = 1'b0, input result_t typed_res = '0);
        result_t predicted;
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 3){1'b0}}, walls};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_move(cmd, walls);
        expected_results.push_back(typed ? typed_res : predicted);
        if (cmd == CMD_RESTART)
            restarts_sent++;
        else
            steps_sent++;
        if (predicted.stuck)
            stuck_predicted++;
    endtask

    // One register write; the caller lowers cfg_valid after the last one.
    task automatic write_start_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        case (idx)
            CFG_START_COL:     start_col_q = value;
            CFG_START_ROW:     start_row_q = value;
            CFG_START_HEADING: start_dir_q = value & 3;
            default:           ;
        endcase
    endtask

    task automatic program_start(input logic [3:0] col, input logic [3:0] row,
                                 input logic [3:0] heading);
        write_start_reg(CFG_START_COL, col);
        write_start_reg(CFG_START_ROW, row);
        write_start_reg(CFG_START_HEADING, heading);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stalls, switched off during the quiet phase.
    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result checker.
    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (expected_results.size() == 0)
                log_failure($sformatf("result with nothing expected: %s", show_result(got)));
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.new_heading !== want.new_heading || got.turn_steps !== want.turn_steps
                    || got.turned_left !== want.turned_left || got.cell_col !== want.cell_col
                    || got.cell_row !== want.cell_row || got.cell_visits !== want.cell_visits
                    || got.stuck !== want.stuck || m_tdata[M_TDATA_W-1:RES_W] !== '0)
                    log_failure($sformatf("result %0d: expected %s, got %s (fill %b)",
                                          results_checked, show_result(want),
                                          show_result(got), m_tdata[M_TDATA_W-1:RES_W]));
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] walls;
        int roll;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_STEP;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_START_COL;
        cfg_data    = '0;
        quiet       = 1'b0;
        start_col_q = START_COL_RST;
        start_row_q = START_ROW_RST;
        start_dir_q = START_HEADING_RST;
        robot_col   = start_col_q;
        robot_row   = start_row_q;
        robot_dir   = start_dir_q;
        foreach (visit_count[k])
            visit_count[k] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset start values.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_command(DIRECTED[i].cmd, DIRECTED[i].walls, DIRECTED[i].typed, DIRECTED[i].exp);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each from a new start: the four corners, then random ones.
        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p == 2);
            case (p)
                0:       program_start(4'd0,  4'd0,  HEAD_UP);
                1:       program_start(4'd15, 4'd15, HEAD_LEFT);
                2:       program_start(4'd15, 4'd0,  HEAD_RIGHT);
                3:       program_start(4'd0,  4'd15, {2'b11, HEAD_DOWN});
                default: program_start(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                       4'($urandom_range(0, 15)));
            endcase
            issue_command(CMD_RESTART, 3'($urandom_range(0, 7)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                // Mostly steps with sparse walls, some fully walled, a few restarts.
                if (roll < 2)
                    issue_command(CMD_RESTART, 3'($urandom_range(0, 7)));
                else if (roll < 10)
                    issue_command(CMD_STEP, 3'b111);
                else
                begin
                    walls = {$urandom_range(0, 99) < 25, $urandom_range(0, 99) < 25,
                             $urandom_range(0, 99) < 25};
                    issue_command(CMD_STEP, walls);
                end
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end
        quiet = 1'b0;

        // Let any stray result show up.
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d steps (%0d stuck) and %0d restarts from %0d start settings, %0d register writes.",
                 steps_sent, stuck_predicted, restarts_sent, PHASES + 1, cfg_writes);
        $display("Compared %0d results, %0d failures.", results_checked, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/lvms_pkg.sv
sv/lvms_store.sv
sv/lvms_seq.sv
sv/least_visited_maze_step_unit.sv
sv/lvms_checker.sv
test/least_visited_maze_step_unit_tb.sv
